// ----- rtl/sorted_timeout_queue_macros.svh -----
// Assertion macros shared by the timer queue checker
`ifndef SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define STQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer queue check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer queue check failed");

`endif

// ----- rtl/stq_pkg.sv -----
// Types, codes and sizes of the sorted timeout queue
`timescale 1ns / 1ps
package stq_pkg;

   localparam int TIMER_SLOTS = 32;
   localparam int SLOT_W      = $clog2(TIMER_SLOTS);
   localparam int DL_W        = 32;
   localparam int LINK_MEM_W  = DL_W + SLOT_W;
   localparam int DATA_MEM_W  = 4 + 32;
   localparam logic [DL_W-1:0]   NEVER    = 32'hffffffff;
   localparam logic [SLOT_W-1:0] SENTINEL = '0;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_FREE    = 3'd1,
      OP_INIT    = 3'd2,
      OP_SETTIME = 3'd3,
      OP_TICK    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NOFREE = 2'd1,
      STAT_WRONG  = 2'd2
   } stat_type;

   typedef enum logic [1:0] {
      SS_FREE  = 2'd0,
      SS_ALLOC = 2'd1,
      SS_RUN   = 2'd2
   } slot_state_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_EXPIRY = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_W1,
      ST_INS_W2,
      ST_TK_RD,
      ST_TK_CMP,
      ST_TK_LAST
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [4:0]  slot;
      logic [3:0]  dest;
      logic [31:0] data;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [3:0]        dest;
      logic [31:0]       data;
   } pend_type;

endpackage

// ----- rtl/stq_ram.sv -----
// Generic one-write one-read synchronous RAM with registered read data
`timescale 1ns / 1ps
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/sorted_timeout_queue.sv -----
// Top level of the sorted timeout queue: sequencer, slot states and list memories
//
//  channel   ports                         handshake
//  request   req_op .. req_delay           start high while busy low
//  response  rsp_kind .. rsp_last          rsp_strobe for one cycle
//
// Free, init, unknown ops, a tick with no walk and a settime at the list front
// answer in the cycle after the request.
// Alloc scans the slot states one per cycle, from slot 0 up to slot TIMER_SLOTS-1.
// Settime behind the front walks the list memory, a read state and a compare state per
// visited slot (the link memory has registered read data), then states W1 and W2 write.
// Tick reads and compares each slot on its walk and emits one expiry per expired slot;
// the walk ends in ST_TK_LAST at the sentinel, or on reading a slot still running.
// Reset is synchronous; no clearing pass. Responses cannot be held off.
`timescale 1ns / 1ps
module sorted_timeout_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [4:0]         req_slot,
   input  logic [3:0]         req_queue_id,
   input  logic signed [31:0] req_payload,
   input  logic [31:0]        req_delay,
   output logic               rsp_strobe,
   output logic               rsp_kind,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_slot_out,
   output logic [3:0]         rsp_dest_queue,
   output logic signed [31:0] rsp_expiry_data,
   output logic               rsp_last
);

   localparam int SW = stq_pkg::SLOT_W;
   localparam int DW = stq_pkg::DL_W;

   stq_pkg::state_type      state_ff, state_in;
   stq_pkg::slot_state_type status_ff [stq_pkg::TIMER_SLOTS];
   stq_pkg::slot_state_type status_in [stq_pkg::TIMER_SLOTS];
   logic [SW-1:0]  cur_ff, cur_in, prev_ff, prev_in, head_ff, head_in;
   logic [SW-1:0]  scan_ff, scan_in, insslot_ff, insslot_in;
   logic [DW-1:0]  prevdl_ff, prevdl_in, insdl_ff, insdl_in;
   logic [DW-1:0]  tick_ff, tick_in, earliest_ff, earliest_in;
   logic           first_ff, first_in;
   stq_pkg::pend_type pend_ff, pend_in;
   stq_pkg::rsp_type  rsp_ff, rsp_in;
   logic           strobe_ff, strobe_in;

   logic                             a_wr_en;
   logic [SW-1:0]                    a_wr_addr;
   logic [stq_pkg::LINK_MEM_W-1:0]   a_wr_data, a_rd;
   logic                             b_wr_en;
   logic [stq_pkg::DATA_MEM_W-1:0]   b_wr_data, b_rd;

   logic [SW+4:0]  slot_ext;
   logic [SW-1:0]  s_idx;
   logic           s_ok, accept;
   logic [DW-1:0]  dl_new, tick_new, a_dl;
   logic [SW-1:0]  a_lk;
   logic           ins_stop, tk_exp, set_ok, set_front, tick_walk;
   stq_pkg::op_type op;

   // widen a slot index to the 5-bit port field
   function automatic logic [4:0] to_port(input logic [SW-1:0] idx);
      logic [SW+4:0] w;
      w = {5'b0, idx};
      return w[4:0];
   endfunction

   // link memory: deadline and next slot
   stq_ram #(.WIDTH(stq_pkg::LINK_MEM_W), .DEPTH(stq_pkg::TIMER_SLOTS)) u_link_mem (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_addr (cur_ff),
      .rd_data (a_rd)
   );

   // data memory: destination queue and data word
   stq_ram #(.WIDTH(stq_pkg::DATA_MEM_W), .DEPTH(stq_pkg::TIMER_SLOTS)) u_data_mem (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (s_idx),
      .wr_data (b_wr_data),
      .rd_addr (cur_ff),
      .rd_data (b_rd)
   );

   // decode the request and the memory words
   assign op        = stq_pkg::op_type'(req_op);
   assign accept    = start && !busy;
   assign slot_ext  = {{SW{1'b0}}, req_slot};
   assign s_idx     = slot_ext[SW-1:0];
   assign s_ok      = slot_ext < (SW+5)'(stq_pkg::TIMER_SLOTS);
   assign dl_new    = req_delay + tick_ff;
   assign tick_new  = tick_ff + 32'd1;
   assign a_dl      = a_rd[stq_pkg::LINK_MEM_W-1:SW];
   assign a_lk      = a_rd[SW-1:0];
   assign ins_stop  = !first_ff && (insdl_ff <= a_dl);
   assign tk_exp    = a_dl <= tick_ff;
   assign set_ok    = s_ok && (status_ff[s_idx] == stq_pkg::SS_ALLOC);
   assign set_front = dl_new <= earliest_ff;
   assign tick_walk = (earliest_ff <= tick_new) && (head_ff != stq_pkg::SENTINEL);
   assign b_wr_data = {req_queue_id, req_payload};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (accept) begin
               if (op == stq_pkg::OP_ALLOC) begin
                  state_in = stq_pkg::ST_ALLOC;
               end else if (op == stq_pkg::OP_SETTIME && set_ok && !set_front) begin
                  state_in = stq_pkg::ST_INS_RD;
               end else if (op == stq_pkg::OP_TICK && tick_walk) begin
                  state_in = stq_pkg::ST_TK_RD;
               end
            end
         end
         stq_pkg::ST_ALLOC: begin
            if (status_ff[scan_ff] == stq_pkg::SS_FREE
                  || scan_ff == SW'(stq_pkg::TIMER_SLOTS - 1)) begin
               state_in = stq_pkg::ST_IDLE;
            end
         end
         stq_pkg::ST_INS_RD:  state_in = stq_pkg::ST_INS_CMP;
         stq_pkg::ST_INS_CMP: begin
            if (ins_stop || a_lk == stq_pkg::SENTINEL) begin
               state_in = stq_pkg::ST_INS_W1;
            end else begin
               state_in = stq_pkg::ST_INS_RD;
            end
         end
         stq_pkg::ST_INS_W1:  state_in = stq_pkg::ST_INS_W2;
         stq_pkg::ST_INS_W2:  state_in = stq_pkg::ST_IDLE;
         stq_pkg::ST_TK_RD:   state_in = stq_pkg::ST_TK_CMP;
         stq_pkg::ST_TK_CMP: begin
            if (!tk_exp) begin
               state_in = stq_pkg::ST_IDLE;
            end else if (a_lk == stq_pkg::SENTINEL) begin
               state_in = stq_pkg::ST_TK_LAST;
            end else begin
               state_in = stq_pkg::ST_TK_RD;
            end
         end
         stq_pkg::ST_TK_LAST: state_in = stq_pkg::ST_IDLE;
         default:             state_in = stq_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory writes and responses
   always_comb begin
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      head_in     = head_ff;
      scan_in     = scan_ff;
      insslot_in  = insslot_ff;
      prevdl_in   = prevdl_ff;
      insdl_in    = insdl_ff;
      tick_in     = tick_ff;
      earliest_in = earliest_ff;
      first_in    = first_ff;
      pend_in     = pend_ff;
      status_in   = status_ff;
      rsp_in      = '0;
      strobe_in   = 1'b0;
      a_wr_en     = 1'b0;
      a_wr_addr   = prev_ff;
      a_wr_data   = {prevdl_ff, insslot_ff};
      b_wr_en     = 1'b0;
      unique case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.kind   = stq_pkg::KIND_STATUS;
               rsp_in.status = stq_pkg::STAT_OK;
               rsp_in.slot   = req_slot;
               rsp_in.last   = 1'b1;
               unique case (op)
                  stq_pkg::OP_ALLOC: begin
                     scan_in = '0;
                  end
                  stq_pkg::OP_FREE: begin
                     strobe_in = 1'b1;
                     if (!s_ok || status_ff[s_idx] == stq_pkg::SS_RUN) begin
                        rsp_in.status = stq_pkg::STAT_WRONG;
                     end else begin
                        status_in[s_idx] = stq_pkg::SS_FREE;
                     end
                  end
                  stq_pkg::OP_INIT: begin
                     strobe_in = 1'b1;
                     if (set_ok) begin
                        b_wr_en = 1'b1;
                     end else begin
                        rsp_in.status = stq_pkg::STAT_WRONG;
                     end
                  end
                  stq_pkg::OP_SETTIME: begin
                     if (!set_ok) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = stq_pkg::STAT_WRONG;
                     end else begin
                        status_in[s_idx] = stq_pkg::SS_RUN;
                        insdl_in         = dl_new;
                        insslot_in       = s_idx;
                        if (set_front) begin
                           // new front of the list
                           a_wr_en     = 1'b1;
                           a_wr_addr   = s_idx;
                           a_wr_data   = {dl_new, head_ff};
                           head_in     = s_idx;
                           earliest_in = dl_new;
                           strobe_in   = 1'b1;
                        end else begin
                           cur_in   = head_ff;
                           first_in = 1'b1;
                        end
                     end
                  end
                  stq_pkg::OP_TICK: begin
                     tick_in = tick_new;
                     if (tick_walk) begin
                        cur_in   = head_ff;
                        first_in = 1'b1;
                     end else begin
                        strobe_in   = 1'b1;
                        rsp_in.slot = '0;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         stq_pkg::ST_ALLOC: begin
            rsp_in.kind = stq_pkg::KIND_STATUS;
            rsp_in.last = 1'b1;
            if (status_ff[scan_ff] == stq_pkg::SS_FREE) begin
               status_in[scan_ff] = stq_pkg::SS_ALLOC;
               strobe_in          = 1'b1;
               rsp_in.status      = stq_pkg::STAT_OK;
               rsp_in.slot        = to_port(scan_ff);
            end else if (scan_ff == SW'(stq_pkg::TIMER_SLOTS - 1)) begin
               strobe_in     = 1'b1;
               rsp_in.status = stq_pkg::STAT_NOFREE;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         stq_pkg::ST_INS_RD: begin
         end
         stq_pkg::ST_INS_CMP: begin
            // advance unless the new slot goes before the one just read
            if (!ins_stop) begin
               prev_in   = cur_ff;
               prevdl_in = a_dl;
               cur_in    = a_lk;
               first_in  = 1'b0;
            end
         end
         stq_pkg::ST_INS_W1: begin
            a_wr_en = 1'b1;
         end
         stq_pkg::ST_INS_W2: begin
            a_wr_en       = 1'b1;
            a_wr_addr     = insslot_ff;
            a_wr_data     = {insdl_ff, cur_ff};
            strobe_in     = 1'b1;
            rsp_in.kind   = stq_pkg::KIND_STATUS;
            rsp_in.status = stq_pkg::STAT_OK;
            rsp_in.slot   = to_port(insslot_ff);
            rsp_in.last   = 1'b1;
         end
         stq_pkg::ST_TK_RD: begin
         end
         stq_pkg::ST_TK_CMP: begin
            rsp_in.kind = stq_pkg::KIND_EXPIRY;
            rsp_in.slot = to_port(pend_ff.slot);
            rsp_in.dest = pend_ff.dest;
            rsp_in.data = pend_ff.data;
            if (tk_exp) begin
               // hold this slot back until the next one is known
               strobe_in         = !first_ff;
               first_in          = 1'b0;
               pend_in.slot      = cur_ff;
               pend_in.dest      = b_rd[35:32];
               pend_in.data      = b_rd[31:0];
               status_in[cur_ff] = stq_pkg::SS_ALLOC;
               cur_in            = a_lk;
               if (a_lk == stq_pkg::SENTINEL) begin
                  head_in     = stq_pkg::SENTINEL;
                  earliest_in = stq_pkg::NEVER;
               end
            end else begin
               strobe_in   = 1'b1;
               rsp_in.last = 1'b1;
               head_in     = cur_ff;
               earliest_in = a_dl;
            end
         end
         stq_pkg::ST_TK_LAST: begin
            strobe_in   = 1'b1;
            rsp_in.kind = stq_pkg::KIND_EXPIRY;
            rsp_in.slot = to_port(pend_ff.slot);
            rsp_in.dest = pend_ff.dest;
            rsp_in.data = pend_ff.data;
            rsp_in.last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= stq_pkg::ST_IDLE;
         head_ff     <= stq_pkg::SENTINEL;
         tick_ff     <= '0;
         earliest_ff <= stq_pkg::NEVER;
         strobe_ff   <= 1'b0;
         for (int i = 0; i < stq_pkg::TIMER_SLOTS; i++) begin
            status_ff[i] <= (i == 0) ? stq_pkg::SS_RUN : stq_pkg::SS_FREE;
         end
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tick_ff     <= tick_in;
         earliest_ff <= earliest_in;
         strobe_ff   <= strobe_in;
         status_ff   <= status_in;
      end
   end

   // walk and response payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      scan_ff    <= scan_in;
      insslot_ff <= insslot_in;
      prevdl_ff  <= prevdl_in;
      insdl_ff   <= insdl_in;
      first_ff   <= first_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign busy            = state_ff != stq_pkg::ST_IDLE;
   assign rsp_strobe      = strobe_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_status      = rsp_ff.status;
   assign rsp_slot_out    = rsp_ff.slot;
   assign rsp_dest_queue  = rsp_ff.dest;
   assign rsp_expiry_data = rsp_ff.data;
   assign rsp_last        = rsp_ff.last;

endmodule

// ----- rtl/stq_checker.sv -----
// Port-level checks of the sorted timeout queue and their binding
`timescale 1ns / 1ps
`include "sorted_timeout_queue_macros.svh"
module stq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_op,
   input logic [4:0]         req_slot,
   input logic [3:0]         req_queue_id,
   input logic signed [31:0] req_payload,
   input logic [31:0]        req_delay,
   input logic               rsp_strobe,
   input logic               rsp_kind,
   input logic [1:0]         rsp_status,
   input logic [4:0]         rsp_slot_out,
   input logic [3:0]         rsp_dest_queue,
   input logic signed [31:0] rsp_expiry_data,
   input logic               rsp_last
);

   // expiry messages always carry an ok status
   `STQ_ASSERT_NOW(a_expiry_ok, rsp_strobe && rsp_kind, rsp_status == stq_pkg::STAT_OK)
   // a status response is the only response of its request
   `STQ_ASSERT_NOW(a_status_last, rsp_strobe && !rsp_kind, rsp_last)
   // the final response finds the block idle
   `STQ_ASSERT_NOW(a_last_idle, rsp_strobe && rsp_last, !busy)
   // more responses pending means the block stays busy
   `STQ_ASSERT_NOW(a_more_busy, rsp_strobe && !rsp_last, busy)
   // free answers on the next cycle
   `STQ_ASSERT_NEXT(a_free_quick, start && !busy && req_op == stq_pkg::OP_FREE,
      rsp_strobe && rsp_last && rsp_slot_out == $past(req_slot))

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (.*);
